// ===== sv/nand_bad_block_skip_mapper_defines.svh =====
// Assertion macros shared by the bad-block mapper checkers.
// Needs nothing else; include by bare file name.
`ifndef NAND_BAD_BLOCK_SKIP_MAPPER_DEFINES_SVH
`define NAND_BAD_BLOCK_SKIP_MAPPER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBSM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBSM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bbsm_pkg.sv =====
// Shared constants and types of the bad-block skip mapper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bbsm_pkg;

   localparam int NUM_BLOCKS = 1024;
   localparam int ADDR_BITS  = 28;

   localparam int CSR_W      = 5;
   localparam int CSR_RESET  = 17;

   localparam int BIDX_W     = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
   localparam int SH_W       = $clog2(ADDR_BITS + 1);

   // bad map geometry: one row of ROW_BITS blocks per memory word
   localparam int ROW_BITS   = 16;
   localparam int SEL_W      = $clog2(ROW_BITS);
   localparam int PC_W       = $clog2(ROW_BITS + 1);
   localparam int ROWS       = (NUM_BLOCKS + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam int P_W        = BIDX_W + ADDR_BITS + 1;

   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W     = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      OP_XLATE     = 2'd0,
      OP_MARK_BAD  = 2'd1,
      OP_MARK_GOOD = 2'd2,
      OP_NOP       = 2'd3
   } op_type;

   // classified command; blk is the logical block for a translate and
   // the physical block for a mark
   typedef struct packed {
      op_type                 op;
      logic                   fail;
      logic [BIDX_W-1:0]      blk;
      logic [ADDR_BITS-1:0]   in_off;
      logic [SH_W-1:0]        sh;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_slot_type;

endpackage

// ===== sv/nand_bad_block_skip_mapper.sv =====
// Bad-block skip mapper for a flash device. Requests translate a logical byte offset to a
// physical one by skipping erase blocks marked bad, or mark one block bad or good; each
// request gives exactly one response. The map starts all good after reset. A translate of
// logical block k reads the 16-block map rows in order up to the row holding the (k+1)-th
// good block (at most 63 rows before it), then walks that row bit by bit up to the
// block's bit position (at most 15) and builds the address; the map memory has one read
// port and delivers one row per cycle. A translate that runs out of good blocks reads every
// row; a translate rejected up front or an unused opcode skips the map and a mark does a
// read-modify-write of one row; a stalled response adds its stall to the next item.
// Up to two requests wait in a queue while the engine works and a result waits to be taken.
// Write block_shift only while no request is outstanding.
`timescale 1ns / 1ps

module nand_bad_block_skip_mapper import bbsm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_W-1:0]      csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [ADDR_BITS-1:0]  req_logical_address,
   input  logic [BIDX_W-1:0]     req_block_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ADDR_BITS-1:0]  rsp_physical_address,
   output logic                  rsp_status
);

   q_slot_type push;
   q_slot_type head;
   logic       q_full;
   logic       pop;

   bbsm_front u_front (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_logical_address (req_logical_address),
      .req_block_index     (req_block_index),
      .q_full              (q_full),
      .push_o              (push)
   );

   bbsm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push_i (push),
      .full_o (q_full),
      .head_o (head),
      .pop_i  (pop)
   );

   bbsm_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head_i               (head),
      .pop_o                (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_physical_address (rsp_physical_address),
      .rsp_status           (rsp_status)
   );

endmodule

// ===== sv/bbsm_front.sv =====
// Front end: block_shift register, input handshake and command classification.
// Depends on bbsm_pkg; feeds bbsm_queue.
`timescale 1ns / 1ps

module bbsm_front import bbsm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_W-1:0]      csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [ADDR_BITS-1:0]  req_logical_address,
   input  logic [BIDX_W-1:0]     req_block_index,
   input  logic                  q_full,
   output q_slot_type            push_o
);

   logic [CSR_W-1:0]     block_shift_ff;
   logic [SH_W-1:0]      sh;
   logic [ADDR_BITS-1:0] k_full;
   logic [ADDR_BITS-1:0] off_mask;
   cmd_type              cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_shift_ff <= CSR_W'(CSR_RESET);
      end else if (csr_write_enable) begin
         block_shift_ff <= csr_write_data;
      end
   end

   always_comb begin
      // shifts past the address width leave the whole address in-block
      sh       = (int'(block_shift_ff) > ADDR_BITS) ? SH_W'(ADDR_BITS) : SH_W'(block_shift_ff);
      k_full   = req_logical_address >> sh;
      off_mask = ~({ADDR_BITS{1'b1}} << sh);

      cmd        = '0;
      cmd.op     = OP_NOP;
      cmd.sh     = sh;
      cmd.in_off = req_logical_address & off_mask;
      unique case (op_type'(req_opcode)) inside
         OP_XLATE: begin
            cmd.op   = OP_XLATE;
            cmd.blk  = BIDX_W'(k_full);
            cmd.fail = ({{(64 - ADDR_BITS){1'b0}}, k_full} >= 64'(NUM_BLOCKS));
         end
         OP_MARK_BAD, OP_MARK_GOOD: begin
            // drop marks outside the device
            if (32'(req_block_index) < NUM_BLOCKS) begin
               cmd.op = op_type'(req_opcode);
            end
            cmd.blk = req_block_index;
         end
         default: begin
            cmd.op = OP_NOP;
         end
      endcase
   end

   assign req_ready    = !q_full;
   assign push_o.valid = req_valid && !q_full;
   assign push_o.cmd   = cmd;

endmodule

// ===== sv/bbsm_queue.sv =====
// Short command queue between the front end and the map engine.
// Depends on bbsm_pkg.
`timescale 1ns / 1ps

module bbsm_queue import bbsm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_slot_type push_i,
   output logic       full_o,
   output q_slot_type head_o,
   input  logic       pop_i
);

   cmd_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full_o       = (cnt_ff == QCNT_W'(QDEPTH));
   assign head_o.valid = (cnt_ff != '0);
   assign head_o.cmd   = slot_ff[rd_ptr_ff];

   assign do_push = push_i.valid && !full_o;
   assign do_pop  = pop_i && head_o.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_i.cmd;
      end
   end

endmodule

// ===== sv/bbsm_back.sv =====
// Map engine: bad-block memory, row scan, bit walk, address build, result register.
// Depends on bbsm_pkg; takes commands from bbsm_queue.
`timescale 1ns / 1ps

module bbsm_back import bbsm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  q_slot_type            head_i,
   output logic                  pop_o,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ADDR_BITS-1:0]  rsp_physical_address,
   output logic                  rsp_status
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MARK = 6'b000010,
      S_SCAN = 6'b000100,
      S_PICK = 6'b001000,
      S_CALC = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cur_ff, cur_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [CNT_W-1:0]     good_ff, good_in;
   logic [SEL_W-1:0]     rem_ff, rem_in;
   logic [SEL_W-1:0]     bit_ff, bit_in;
   logic [ROW_BITS-1:0]  bits_ff, bits_in;
   logic [BIDX_W-1:0]    blk_ff, blk_in;
   logic [ADDR_BITS-1:0] res_addr_ff, res_addr_in;
   logic                 res_stat_ff, res_stat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0] rsp_addr_ff, rsp_addr_in;
   logic                 rsp_stat_ff, rsp_stat_in;

   // bad map: one bit per block, set = bad; a row never written reads all good
   logic [ROW_BITS-1:0]  mem [ROWS];
   logic [ROWS-1:0]      row_vld_ff;
   logic [ROW_BITS-1:0]  rdata_ff;
   logic                 rd_vld_ff;
   logic                 rd_en, wr_en;
   logic [ROW_W-1:0]     rd_addr, wr_addr;
   logic [ROW_BITS-1:0]  wr_data;

   logic [ROW_BITS-1:0]  eff_row;
   logic [ROW_BITS-1:0]  good_bits;
   logic [PC_W-1:0]      pc;
   logic [CNT_W:0]       sum;
   logic [CNT_W-1:0]     diff;
   logic [P_W-1:0]       paddr;
   logic [SEL_W-1:0]     mark_bit;

   assign eff_row  = rd_vld_ff ? rdata_ff : '0;
   assign mark_bit = SEL_W'(cur_ff.blk);

   always_comb begin
      for (int i = 0; i < ROW_BITS; i++) begin
         good_bits[i] = !eff_row[i] && ((int'(row_ff) * ROW_BITS + i) < NUM_BLOCKS);
      end
      pc = '0;
      for (int i = 0; i < ROW_BITS; i++) begin
         pc = pc + PC_W'(good_bits[i]);
      end
      sum   = (CNT_W + 1)'(good_ff) + (CNT_W + 1)'(pc);
      diff  = CNT_W'(cur_ff.blk) - good_ff;
      paddr = (P_W'(blk_ff) << cur_ff.sh) + P_W'(cur_ff.in_off);
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      row_in       = row_ff;
      good_in      = good_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      bits_in      = bits_ff;
      blk_in       = blk_ff;
      res_addr_in  = res_addr_ff;
      res_stat_in  = res_stat_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop_o        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = ROW_W'(cur_ff.blk >> SEL_W);
      wr_data      = eff_row;

      unique case (state_ff)
         S_IDLE: begin
            if (head_i.valid) begin
               pop_o       = 1'b1;
               cur_in      = head_i.cmd;
               res_addr_in = '0;
               res_stat_in = 1'b0;
               unique case (head_i.cmd.op) inside
                  OP_XLATE: begin
                     if (head_i.cmd.fail) begin
                        res_stat_in = 1'b1;
                        state_in    = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        row_in   = '0;
                        good_in  = '0;
                        state_in = S_SCAN;
                     end
                  end
                  OP_MARK_BAD, OP_MARK_GOOD: begin
                     rd_en    = 1'b1;
                     rd_addr  = ROW_W'(head_i.cmd.blk >> SEL_W);
                     state_in = S_MARK;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_MARK: begin
            // read-modify-write of the block's row
            wr_en             = 1'b1;
            wr_data[mark_bit] = (cur_ff.op == OP_MARK_BAD);
            state_in          = S_DONE;
         end
         S_SCAN: begin
            if (sum > (CNT_W + 1)'(cur_ff.blk)) begin
               bits_in  = good_bits;
               rem_in   = SEL_W'(diff);
               bit_in   = '0;
               state_in = S_PICK;
            end else if (row_ff == ROW_W'(ROWS - 1)) begin
               res_stat_in = 1'b1;
               state_in    = S_DONE;
            end else begin
               // prefetch the next row so one row retires per cycle
               good_in = CNT_W'(sum);
               row_in  = row_ff + 1'b1;
               rd_en   = 1'b1;
               rd_addr = row_ff + 1'b1;
            end
         end
         S_PICK: begin
            bit_in = bit_ff + 1'b1;
            if (bits_ff[bit_ff]) begin
               if (rem_ff == '0) begin
                  blk_in   = BIDX_W'({row_ff, bit_ff});
                  state_in = S_CALC;
               end else begin
                  rem_in = rem_ff - 1'b1;
               end
            end
         end
         S_CALC: begin
            if (paddr[P_W-1:ADDR_BITS] != '0) begin
               res_addr_in = '0;
               res_stat_in = 1'b1;
            end else begin
               res_addr_in = paddr[ADDR_BITS-1:0];
               res_stat_in = 1'b0;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the result register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = res_addr_ff;
               rsp_stat_in  = res_stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         row_vld_ff   <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            row_vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= row_vld_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      row_ff      <= row_in;
      good_ff     <= good_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      bits_ff     <= bits_in;
      blk_ff      <= blk_in;
      res_addr_ff <= res_addr_in;
      res_stat_ff <= res_stat_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_addr_ff;
   assign rsp_status           = rsp_stat_ff;

endmodule

// ===== sv/bbsm_checker.sv =====
// Port-level checker for the bad-block skip mapper, bound to the top level.
// Depends on bbsm_pkg and nand_bad_block_skip_mapper_defines.svh.
`timescale 1ns / 1ps
`include "nand_bad_block_skip_mapper_defines.svh"

module bbsm_port_checker import bbsm_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [ADDR_BITS-1:0]  rsp_physical_address,
   input logic                  rsp_status
);

   // queue slots, engine and result register
   localparam int CAP   = QDEPTH + 2;
   localparam int OUT_W = $clog2(CAP + 1);

   logic [OUT_W-1:0] outstanding_ff, outstanding_in;
   logic             req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_xfer && !rsp_xfer) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (rsp_xfer && !req_xfer) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `BBSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_physical_address) && $stable(rsp_status),
      "response dropped or changed while stalled")

   `BBSM_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && rsp_status,
      rsp_physical_address == '0, "failed translate carries a nonzero address")

   `BBSM_ASSERT_NOW(a_rsp_owed, clock, reset, rsp_valid,
      outstanding_ff != '0, "response without an outstanding request")

   `BBSM_ASSERT_NOW(a_capacity, clock, reset, req_xfer,
      outstanding_ff < OUT_W'(CAP), "request taken beyond internal capacity")

endmodule

bind nand_bad_block_skip_mapper bbsm_port_checker u_bbsm_checker (.*);
